// ----- sv/assert_macros.svh -----
// Assertion macros for the backprojection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DPB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpb assertion failed");

// Next-cycle implication, checked out of reset.
`define DPB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpb assertion failed");

`endif

// ----- sv/dpb_pkg.sv -----
// Types, widths and register codes for the depth pixel backprojection core.
`default_nettype none

package dpb_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int DEPTH_BITS  = 16;
  localparam int COLOR_BITS  = 8;
  localparam int GAIN_BITS   = 24;
  localparam int RECIP_BITS  = 24;
  localparam int CENTER_BITS = INDEX_BITS + 1;
  localparam int Z_BITS      = FRAC_BITS + 8;
  localparam int XY_BITS     = FRAC_BITS + 9;

  localparam int GAIN_SHIFT  = 16;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_SPLIT = 12;

  localparam int ZPROD_BITS  = DEPTH_BITS + GAIN_BITS;
  localparam int ZSUM_BITS   = ZPROD_BITS + 1;
  localparam int MAG_BITS    = CENTER_BITS + Z_BITS;
  localparam int PHI_BITS    = MAG_BITS + RECIP_BITS - RECIP_SPLIT;
  localparam int PLO_BITS    = MAG_BITS + RECIP_SPLIT + 1;

  localparam int NUM_STAGES  = 5;

  localparam int IN_DATA_BITS  = 2 * INDEX_BITS + DEPTH_BITS + 3 * COLOR_BITS;
  localparam int IN_TDATA_BITS = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 2 * XY_BITS + Z_BITS + 3 * COLOR_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_TDATA_BITS - OUT_DATA_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam longint unsigned Z_ROUND  = 64'd1 << (GAIN_SHIFT - 1);
  localparam longint unsigned XY_ROUND = 64'd1 << (RECIP_SHIFT - 1);
  localparam longint unsigned XY_HALF  = 64'd1 << (XY_BITS - 1);

  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic [DEPTH_BITS-1:0]   depth_t;
  typedef logic [COLOR_BITS-1:0]   color_t;
  typedef logic [GAIN_BITS-1:0]    gain_t;
  typedef logic [RECIP_BITS-1:0]   recip_t;
  typedef logic [CENTER_BITS-1:0]  center_t;
  typedef logic [ZPROD_BITS-1:0]   zprod_t;
  typedef logic [ZSUM_BITS-1:0]    zsum_t;
  typedef logic [Z_BITS-1:0]       z_t;
  typedef logic [CENTER_BITS-1:0]  dmag_t;
  typedef logic [MAG_BITS-1:0]     mag_t;
  typedef logic [PHI_BITS-1:0]     phi_t;
  typedef logic [PLO_BITS-1:0]     plo_t;
  typedef logic [RECIP_SPLIT-1:0]  rpart_t;
  typedef logic signed [XY_BITS-1:0] coord_t;
  typedef logic [OUT_PAD_BITS-1:0] out_pad_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEPTH_GAIN  = 3'd0,
    REG_CENTER_COL  = 3'd1,
    REG_CENTER_ROW  = 3'd2,
    REG_INV_FOCAL_X = 3'd3,
    REG_INV_FOCAL_Y = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    gain_t   depth_gain;
    center_t center_col;
    center_t center_row;
    recip_t  inv_focal_x;
    recip_t  inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } pix_color_t;

endpackage

`default_nettype wire

// ----- sv/depth_pixel_backprojection_core.sv -----
// Top level of the pinhole depth pixel backprojection core.
//
// Input stream (in_*): one pixel per beat, tdata holds column, row, raw depth
// and the blue, green, red bytes. A pixel with zero depth is accepted and
// dropped; every other pixel gives one point on the output stream (out_*):
// x, y, z in metres with 16 fraction bits and the color bytes unchanged.
// Configuration (cfg_*): index/data write channel, always ready; write only
// while no pixel is in flight.
// Throughput: one pixel per clock while out_tready is high; the five register
// stages are set by the gain multiply, z rounding, offset-times-z multiply,
// split reciprocal multiply, and round/clamp.
// Each stage has its own valid bit and advances when empty or when the next
// stage advances, so bubbles are squeezed out and a stalled receiver fills the
// pipe before in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// calibration registers.
`default_nettype none
`include "assert_macros.svh"

module depth_pixel_backprojection_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // column[11:0], row[23:12], depth_value[39:24], blue, green, red
  input  wire logic [dpb_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // point_x[24:0], point_y[49:25], point_z[73:50], out_blue, out_green, out_red
  output logic [dpb_pkg::OUT_TDATA_BITS-1:0]       out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dpb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [dpb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  dpb_pkg::cfg_t       cfg;
  dpb_pkg::pipe_en_t   en;
  logic [dpb_pkg::NUM_STAGES-1:0] v_r;
  logic [dpb_pkg::NUM_STAGES-1:0] v_nxt;
  logic [dpb_pkg::NUM_STAGES-1:0] stage_en;
  dpb_pkg::pix_color_t pix_r [dpb_pkg::NUM_STAGES];

  dpb_pkg::index_t     in_column;
  dpb_pkg::index_t     in_row;
  dpb_pkg::depth_t     in_depth;
  dpb_pkg::pix_color_t in_color;
  logic                in_beat;

  dpb_pkg::z_t     z_s2;
  dpb_pkg::z_t     z_s5;
  dpb_pkg::coord_t point_x;
  dpb_pkg::coord_t point_y;

  assign in_column      = in_tdata[dpb_pkg::INDEX_BITS-1:0];
  assign in_row         = in_tdata[2*dpb_pkg::INDEX_BITS-1 -: dpb_pkg::INDEX_BITS];
  assign in_depth       = in_tdata[2*dpb_pkg::INDEX_BITS+dpb_pkg::DEPTH_BITS-1 -:
                                   dpb_pkg::DEPTH_BITS];
  assign in_color       = dpb_pkg::pix_color_t'(in_tdata[dpb_pkg::IN_DATA_BITS-1 -:
                                                         3*dpb_pkg::COLOR_BITS]);
  assign in_beat        = in_tvalid && in_tready;

  // stage k moves when it is empty or stage k+1 moves
  always_comb begin
    stage_en[dpb_pkg::NUM_STAGES-1] = !v_r[dpb_pkg::NUM_STAGES-1] || out_tready;
    for (int k = dpb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
  end

  assign en = '{s1: stage_en[0], s2: stage_en[1], s3: stage_en[2],
                s4: stage_en[3], s5: stage_en[4]};

  always_comb begin
    v_nxt = v_r;
    if (stage_en[0]) v_nxt[0] = in_tvalid && (in_depth != '0);
    for (int k = 1; k < dpb_pkg::NUM_STAGES; k++) begin
      if (stage_en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) pix_r[0] <= in_color;
    for (int k = 1; k < dpb_pkg::NUM_STAGES; k++) begin
      if (stage_en[k]) pix_r[k] <= pix_r[k-1];
    end
  end

  dpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpb_depth_path u_depth (
    .clk   (clk),
    .en    (en),
    .depth (in_depth),
    .gain  (cfg.depth_gain),
    .z_s2  (z_s2),
    .z_s5  (z_s5)
  );

  dpb_proj_lane u_lane_x (
    .clk    (clk),
    .en     (en),
    .index  (in_column),
    .center (cfg.center_col),
    .recip  (cfg.inv_focal_x),
    .z_s2   (z_s2),
    .coord  (point_x)
  );

  dpb_proj_lane u_lane_y (
    .clk    (clk),
    .en     (en),
    .index  (in_row),
    .center (cfg.center_row),
    .recip  (cfg.inv_focal_y),
    .z_s2   (z_s2),
    .coord  (point_y)
  );

  assign in_tready  = stage_en[0];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = v_r[dpb_pkg::NUM_STAGES-1];
  assign out_tdata  = {dpb_pkg::out_pad_t'(0), pix_r[dpb_pkg::NUM_STAGES-1],
                       z_s5, point_y, point_x};

  `DPB_ASSERT_NXT(a_zero_depth_dropped, in_beat && (in_depth == '0), !v_r[0])
  `DPB_ASSERT_IMP(a_empty_out_takes_input, !out_tvalid, in_tready)
  `DPB_ASSERT_NXT(a_stalled_stage_holds, v_r[2] && !stage_en[3], v_r[2])

endmodule

`default_nettype wire

// ----- sv/dpb_cfg_regs.sv -----
// Configuration register file: index decode and reset values.
`default_nettype none

module dpb_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [dpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [dpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output dpb_pkg::cfg_t                          cfg
);

  dpb_pkg::cfg_t cfg_r;
  dpb_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (dpb_pkg::cfg_reg_t'(cfg_index))
        dpb_pkg::REG_DEPTH_GAIN:  cfg_nxt.depth_gain  = dpb_pkg::gain_t'(cfg_data);
        dpb_pkg::REG_CENTER_COL:  cfg_nxt.center_col  = dpb_pkg::center_t'(cfg_data);
        dpb_pkg::REG_CENTER_ROW:  cfg_nxt.center_row  = dpb_pkg::center_t'(cfg_data);
        dpb_pkg::REG_INV_FOCAL_X: cfg_nxt.inv_focal_x = dpb_pkg::recip_t'(cfg_data);
        dpb_pkg::REG_INV_FOCAL_Y: cfg_nxt.inv_focal_y = dpb_pkg::recip_t'(cfg_data);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_gain  <= dpb_pkg::gain_t'(4294967);
      cfg_r.center_col  <= dpb_pkg::center_t'(651);
      cfg_r.center_row  <= dpb_pkg::center_t'(507);
      cfg_r.inv_focal_x <= dpb_pkg::recip_t'(32388);
      cfg_r.inv_focal_y <= dpb_pkg::recip_t'(32326);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- sv/dpb_depth_path.sv -----
// Depth path: gain multiply, rounding and saturation of z, z delay to the output.
`default_nettype none

module dpb_depth_path (
  input  wire logic                clk,
  input  wire dpb_pkg::pipe_en_t   en,
  input  wire dpb_pkg::depth_t     depth,
  input  wire dpb_pkg::gain_t      gain,
  output dpb_pkg::z_t              z_s2,
  output dpb_pkg::z_t              z_s5
);

  dpb_pkg::zprod_t zprod_r;
  dpb_pkg::z_t     z2_r, z3_r, z4_r, z5_r;
  dpb_pkg::zsum_t  zsum;
  dpb_pkg::zsum_t  zfull;
  dpb_pkg::z_t     z2_nxt;

  always_comb begin
    zsum  = dpb_pkg::zsum_t'(zprod_r) + dpb_pkg::zsum_t'(dpb_pkg::Z_ROUND);
    zfull = zsum >> dpb_pkg::GAIN_SHIFT;
    if (zfull > dpb_pkg::zsum_t'({dpb_pkg::Z_BITS{1'b1}})) begin
      z2_nxt = '1;
    end else begin
      z2_nxt = dpb_pkg::z_t'(zfull);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) zprod_r <= dpb_pkg::zprod_t'(depth) * dpb_pkg::zprod_t'(gain);
    if (en.s2) z2_r <= z2_nxt;
    if (en.s3) z3_r <= z2_r;
    if (en.s4) z4_r <= z3_r;
    if (en.s5) z5_r <= z4_r;
  end

  assign z_s2 = z2_r;
  assign z_s5 = z5_r;

endmodule

`default_nettype wire

// ----- sv/dpb_proj_lane.sv -----
// One projection lane: offset from center, times z, times reciprocal, round and clamp.
`default_nettype none

module dpb_proj_lane (
  input  wire logic               clk,
  input  wire dpb_pkg::pipe_en_t  en,
  input  wire dpb_pkg::index_t    index,
  input  wire dpb_pkg::center_t   center,
  input  wire dpb_pkg::recip_t    recip,
  input  wire dpb_pkg::z_t        z_s2,
  output dpb_pkg::coord_t         coord
);

  dpb_pkg::dmag_t  dmag1_r, dmag2_r;
  logic            neg1_r, neg2_r, neg3_r, neg4_r;
  dpb_pkg::mag_t   mag3_r;
  dpb_pkg::phi_t   phi4_r;
  dpb_pkg::plo_t   plo4_r;
  dpb_pkg::coord_t coord5_r;

  dpb_pkg::center_t twice;
  logic             neg1_nxt;
  dpb_pkg::dmag_t   dmag1_nxt;
  dpb_pkg::rpart_t  recip_hi;
  dpb_pkg::rpart_t  recip_lo;
  dpb_pkg::plo_t    sum;
  dpb_pkg::mag_t    mag_out;
  dpb_pkg::mag_t    mag_sat;
  dpb_pkg::mag_t    mag_neg;
  dpb_pkg::coord_t  coord5_nxt;

  always_comb begin
    twice     = {index, 1'b0};
    neg1_nxt  = twice < center;
    dmag1_nxt = neg1_nxt ? (center - twice) : (twice - center);
  end

  assign recip_hi = recip[dpb_pkg::RECIP_BITS-1 -: dpb_pkg::RECIP_SPLIT];
  assign recip_lo = recip[dpb_pkg::RECIP_SPLIT-1:0];

  always_comb begin
    sum     = dpb_pkg::plo_t'(phi4_r) + (plo4_r >> dpb_pkg::RECIP_SPLIT);
    mag_out = dpb_pkg::mag_t'(sum >> (dpb_pkg::RECIP_SHIFT - dpb_pkg::RECIP_SPLIT));
    if (neg4_r) begin
      mag_sat = (mag_out > dpb_pkg::mag_t'(dpb_pkg::XY_HALF)) ?
                dpb_pkg::mag_t'(dpb_pkg::XY_HALF) : mag_out;
      mag_neg    = dpb_pkg::mag_t'(0) - mag_sat;
      coord5_nxt = dpb_pkg::coord_t'(mag_neg);
    end else begin
      mag_sat = (mag_out > dpb_pkg::mag_t'(dpb_pkg::XY_HALF - 1)) ?
                dpb_pkg::mag_t'(dpb_pkg::XY_HALF - 1) : mag_out;
      mag_neg    = '0;
      coord5_nxt = dpb_pkg::coord_t'(mag_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dmag1_r <= dmag1_nxt;
      neg1_r  <= neg1_nxt;
    end
    if (en.s2) begin
      dmag2_r <= dmag1_r;
      neg2_r  <= neg1_r;
    end
    if (en.s3) begin
      mag3_r <= dpb_pkg::mag_t'(dmag2_r) * dpb_pkg::mag_t'(z_s2);
      neg3_r <= neg2_r;
    end
    if (en.s4) begin
      phi4_r <= dpb_pkg::phi_t'(mag3_r) * dpb_pkg::phi_t'(recip_hi);
      plo4_r <= dpb_pkg::plo_t'(mag3_r) * dpb_pkg::plo_t'(recip_lo)
                + dpb_pkg::plo_t'(dpb_pkg::XY_ROUND);
      neg4_r <= neg3_r;
    end
    if (en.s5) coord5_r <= coord5_nxt;
  end

  assign coord = coord5_r;

endmodule

`default_nettype wire
